>>> sv/utt_pkg.sv
// Shared types and constants for the UTF-8 text terminal writer.
`timescale 1ns / 1ps

package utt_pkg;

  // Request kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  // One stored screen cell.
  typedef struct packed {
    logic [15:0] cp;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic [7:0]  attrs;
  } cell_t;

  // Code point handed from the decoder to the cursor logic.
  typedef struct packed {
    logic        valid;
    logic [15:0] cp;
  } emit_t;

  localparam logic [15:0] CP_SPACE   = 16'h0020;
  localparam logic [15:0] CP_REPLACE = 16'hFFFD;
  localparam logic [15:0] CP_LF      = 16'h000A;
  localparam logic [15:0] CP_CR      = 16'h000D;
  localparam logic [15:0] CP_BS      = 16'h0008;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [7:0] RESET_FG = 8'd7;
  localparam logic [7:0] RESET_BG = 8'd0;

endpackage

>>> sv/utt_decode.sv
// UTF-8 byte decoder with its sequence state, at most one code point per byte.
`timescale 1ns / 1ps

module utt_decode import utt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output emit_t      emit_o
);

  logic [15:0] acc_q, acc_d, acc_c;
  logic [1:0]  pend_q, pend_d;
  logic        disc_q, disc_d;
  logic        fresh;

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    disc_d = disc_q;
    emit_o = '0;
    fresh  = 1'b0;
    acc_c  = disc_q ? acc_q : {acc_q[9:0], byte_i[5:0]};

    if (pend_q == 2'd0) begin
      fresh = 1'b1;
    end else if ((byte_i & CONT_MASK) == CONT_CODE) begin
      pend_d = pend_q - 2'd1;
      if (pend_q == 2'd1) begin
        emit_o.valid = !disc_q;
        emit_o.cp    = acc_c;
        acc_d        = '0;
        disc_d       = 1'b0;
      end else begin
        acc_d = acc_c;
      end
    end else begin
      fresh = 1'b1;
    end

    // drop any partial sequence and take the byte as a new one
    if (fresh) begin
      acc_d  = '0;
      pend_d = 2'd0;
      disc_d = 1'b0;
      priority if (!byte_i[7]) begin
        emit_o.valid = 1'b1;
        emit_o.cp    = {8'h00, byte_i};
      end else if ((byte_i & LEAD2_MASK) == LEAD2_CODE) begin
        acc_d  = {11'd0, byte_i[4:0]};
        pend_d = 2'd1;
      end else if ((byte_i & LEAD3_MASK) == LEAD3_CODE) begin
        acc_d  = {12'd0, byte_i[3:0]};
        pend_d = 2'd2;
      end else if ((byte_i & LEAD4_MASK) == LEAD4_CODE) begin
        emit_o.valid = 1'b1;
        emit_o.cp    = CP_REPLACE;
        pend_d       = 2'd3;
        disc_d       = 1'b1;
      end else begin
        pend_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= 2'd0;
      disc_q <= 1'b0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      disc_q <= disc_d;
    end
  end

endmodule

>>> sv/utf8_text_terminal_writer_top.sv
// Top level of the UTF-8 text terminal writer: registers, cell memory and sequencer.
`timescale 1ns / 1ps
//
//   channel   direction  handshake                payload
//   --------  ---------  -----------------------  ---------------------------------------
//   request   in         in_valid_i / in_ready_o  kind_i, data_byte_i, col_i, row_i
//   result    out        out_valid_o / out_ready_i cursor_col_o, cursor_row_o, cell_*_o
//   config    in         psel/penable/pwrite      paddr, pwdata -> prdata, pready
//
// One request at a time. A printable byte is accepted, decoded, written to its cell and
// its result loaded; controls, set cursor and bytes that end no code point skip the cell
// write; a cell read inside the screen waits on the registered read of the cell memory.
// A scroll copies each row one row up and, when rows > 1, lets the last copy drain before
// it blanks the last row, all through the single write port; clear screen blanks the
// whole cell memory.
// After reset a clearing pass blanks the whole memory; no request is taken meanwhile,
// configuration writes are.
// A result that waits on out_ready_i is held in the output register; the next request
// is accepted meanwhile and stalls only at its own result load.

module utf8_text_terminal_writer_top import utt_pkg::*; #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [6:0]  col_i,
  input  logic [5:0]  row_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  cursor_col_o,
  output logic [5:0]  cursor_row_o,
  output logic [15:0] cell_codepoint_o,
  output logic [7:0]  cell_fg_o,
  output logic [7:0]  cell_bg_o,
  output logic [7:0]  cell_attrs_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // index widths of a cell address and widths able to hold the size itself
  localparam int CA    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RA    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CN    = $clog2(MAX_COLS + 1);
  localparam int RN    = $clog2(MAX_ROWS + 1);
  localparam int AW    = RA + CA;
  localparam int DEPTH = 2 ** AW;

  localparam logic [2:0] REG_NUM_COLS  = 3'd0;
  localparam logic [2:0] REG_NUM_ROWS  = 3'd1;
  localparam logic [2:0] REG_FG_COLOR  = 3'd2;
  localparam logic [2:0] REG_BG_COLOR  = 3'd3;
  localparam logic [2:0] REG_ATTR_BITS = 3'd4;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_COPY   = 4'd3;
  localparam logic [3:0] S_BLANK  = 4'd4;
  localparam logic [3:0] S_WRITE  = 4'd5;
  localparam logic [3:0] S_CLEAR  = 4'd6;
  localparam logic [3:0] S_RDWAIT = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // ---------------------------------------------------------------- configuration
  logic [7:0] num_cols_q, num_rows_q, fg_q, bg_q, attr_q;
  logic [2:0] cfg_idx;
  logic       cfg_we;

  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= 8'd80;
      num_rows_q <= 8'd30;
      fg_q       <= RESET_FG;
      bg_q       <= RESET_BG;
      attr_q     <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NUM_COLS:  num_cols_q <= pwdata[7:0];
        REG_NUM_ROWS:  num_rows_q <= {1'b0, pwdata[6:0]};
        REG_FG_COLOR:  fg_q       <= pwdata[7:0];
        REG_BG_COLOR:  bg_q       <= pwdata[7:0];
        REG_ATTR_BITS: attr_q     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NUM_COLS:  prdata = {24'd0, num_cols_q};
      REG_NUM_ROWS:  prdata = {24'd0, num_rows_q};
      REG_FG_COLOR:  prdata = {24'd0, fg_q};
      REG_BG_COLOR:  prdata = {24'd0, bg_q};
      REG_ATTR_BITS: prdata = {24'd0, attr_q};
      default:       prdata = 32'd0;
    endcase
  end

  // saturate the programmed size: zero acts as one, clip at the maximum
  logic [8:0]    ecols9;
  logic [7:0]    erows8;
  logic [CN-1:0] cols_eff;
  logic [RN-1:0] rows_eff, rows_m1;
  logic [CA-1:0] col_last;

  assign ecols9   = (num_cols_q == 8'd0) ? 9'd1 :
                    ({1'b0, num_cols_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {1'b0, num_cols_q};
  assign erows8   = (num_rows_q == 8'd0) ? 8'd1 :
                    (num_rows_q > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : num_rows_q;
  assign cols_eff = CN'(ecols9);
  assign rows_eff = RN'(erows8);
  assign rows_m1  = RN'(rows_eff - 1'b1);
  assign col_last = CA'(cols_eff - 1'b1);

  // ---------------------------------------------------------------- state
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [RA-1:0] sr_q, sr_d;
  logic [CA-1:0] sc_q, sc_d;
  logic          cp_pend_q, cp_pend_d;
  logic [AW-1:0] cp_addr_q, cp_addr_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  cell_t         wr_cell_q, wr_cell_d;
  logic [CN-1:0] col_q, col_d;
  logic [RA-1:0] row_q, row_d;

  kind_e         kind_q;
  logic [7:0]    byte_q;
  logic [6:0]    icol_q;
  logic [5:0]    irow_q;
  cell_t         cell_res_q, cell_res_d;

  logic          out_valid_q, out_valid_d, out_load;
  logic [7:0]    out_col_q;
  logic [5:0]    out_row_q;
  cell_t         out_cell_q;

  // cell memory, one write and one registered read a cycle
  cell_t         cell_mem_q [DEPTH];
  cell_t         mem_rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  cell_t         mem_wdata;

  emit_t         emit;
  logic          dec_step;

  utt_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (dec_step),
    .byte_i (byte_q),
    .emit_o (emit)
  );

  // cursor arithmetic for newline and for a printable code point
  logic [RN-1:0] row_ext, lf_row, pr_base, pr_row;
  logic [CN-1:0] pr_col;
  logic          lf_scroll, pr_wrap, pr_scroll;
  logic          rd_in_range;

  assign row_ext   = RN'(row_q);
  assign lf_scroll = (row_ext + 1) >= rows_eff;
  assign lf_row    = lf_scroll ? rows_m1 : RN'(row_ext + 1'b1);
  // pull a row beyond a shrunk screen back to the last row before printing
  assign pr_base   = (row_ext >= rows_eff) ? rows_m1 : row_ext;
  assign pr_wrap   = col_q >= cols_eff;
  assign pr_scroll = pr_wrap && ((pr_base + 1) >= rows_eff);
  assign pr_row    = !pr_wrap ? pr_base : (pr_scroll ? rows_m1 : RN'(pr_base + 1'b1));
  assign pr_col    = pr_wrap ? '0 : col_q;

  assign rd_in_range = ({2'b00, icol_q} < ecols9) && ({2'b00, irow_q} < erows8);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    sr_d        = sr_q;
    sc_d        = sc_q;
    cp_pend_d   = 1'b0;
    cp_addr_d   = cp_addr_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    wr_cell_d   = wr_cell_q;
    col_d       = col_q;
    row_d       = row_q;
    cell_res_d  = cell_res_q;
    dec_step    = 1'b0;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cp_addr_q;
    mem_wdata   = mem_rd_q;
    mem_re      = 1'b0;
    mem_raddr   = {RA'(irow_q), CA'(icol_q)};
    out_valid_d = out_valid_q && !out_ready_i;

    // a copy read last cycle lands now; it owns the write port
    if (cp_pend_q) begin
      mem_we = 1'b1;
    end

    unique case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '{cp: CP_SPACE, fg: (state_q == S_INIT) ? RESET_FG : fg_q,
                      bg: (state_q == S_INIT) ? RESET_BG : bg_q, attrs: 8'd0};
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        cell_res_d = '0;
        state_d    = S_DONE;
        wr_pend_d  = 1'b0;
        sr_d       = '0;
        sc_d       = '0;
        unique case (kind_q)
          KIND_WRITE: begin
            dec_step = 1'b1;
            if (emit.valid) begin
              priority if (emit.cp == CP_LF) begin
                col_d = '0;
                row_d = RA'(lf_row);
                if (lf_scroll) begin
                  state_d = (rows_eff > RN'(1)) ? S_COPY : S_BLANK;
                end
              end else if (emit.cp == CP_CR) begin
                col_d = '0;
              end else if (emit.cp == CP_BS) begin
                if (col_q != '0) begin
                  col_d = col_q - 1'b1;
                end
              end else begin
                wr_pend_d = 1'b1;
                wr_addr_d = {RA'(pr_row), CA'(pr_col)};
                wr_cell_d = '{cp: emit.cp, fg: fg_q, bg: bg_q, attrs: attr_q};
                col_d     = CN'(pr_col + 1'b1);
                row_d     = RA'(pr_row);
                if (pr_scroll) begin
                  state_d = (rows_eff > RN'(1)) ? S_COPY : S_BLANK;
                end else begin
                  state_d = S_WRITE;
                end
              end
            end
          end
          KIND_CURSOR: begin
            // ignore each axis that lies outside the screen
            if ({2'b00, icol_q} < ecols9) begin
              col_d = CN'(icol_q);
            end
            if ({2'b00, irow_q} < erows8) begin
              row_d = RA'(irow_q);
            end
          end
          KIND_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            clr_d   = '0;
            state_d = S_CLEAR;
          end
          KIND_READ: begin
            if (rd_in_range) begin
              mem_re  = 1'b1;
              state_d = S_RDWAIT;
            end
          end
          default: ;
        endcase
      end

      S_COPY: begin
        // read the row below, write it one row up in the next cycle
        mem_re    = 1'b1;
        mem_raddr = {RA'(sr_q + 1'b1), sc_q};
        cp_pend_d = 1'b1;
        cp_addr_d = {sr_q, sc_q};
        if (sc_q == col_last) begin
          sc_d = '0;
          if ((RN'(sr_q) + 2) >= rows_eff) begin
            state_d = S_BLANK;
          end else begin
            sr_d = sr_q + 1'b1;
          end
        end else begin
          sc_d = sc_q + 1'b1;
        end
      end

      S_BLANK: begin
        // hold while the last copy drains
        if (!cp_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = {RA'(rows_m1), sc_q};
          mem_wdata = '{cp: CP_SPACE, fg: fg_q, bg: bg_q, attrs: 8'd0};
          if (sc_q == col_last) begin
            sc_d    = '0;
            state_d = wr_pend_q ? S_WRITE : S_DONE;
          end else begin
            sc_d = sc_q + 1'b1;
          end
        end
      end

      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr_q;
        mem_wdata = wr_cell_q;
        wr_pend_d = 1'b0;
        state_d   = S_DONE;
      end

      S_RDWAIT: begin
        cell_res_d = mem_rd_q;
        state_d    = S_DONE;
      end

      S_DONE: begin
        // stall here until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      sr_q        <= '0;
      sc_q        <= '0;
      cp_pend_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sr_q        <= sr_d;
      sc_q        <= sc_d;
      cp_pend_q   <= cp_pend_d;
      wr_pend_q   <= wr_pend_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cp_addr_q  <= cp_addr_d;
    wr_addr_q  <= wr_addr_d;
    wr_cell_q  <= wr_cell_d;
    cell_res_q <= cell_res_d;
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_e'(kind_i);
      byte_q <= data_byte_i;
      icol_q <= col_i;
      irow_q <= row_i;
    end
    if (out_load) begin
      out_col_q  <= 8'(col_q);
      out_row_q  <= 6'(row_q);
      out_cell_q <= cell_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= cell_mem_q[mem_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_col_o     = out_col_q;
  assign cursor_row_o     = out_row_q;
  assign cell_codepoint_o = out_cell_q.cp;
  assign cell_fg_o        = out_cell_q.fg;
  assign cell_bg_o        = out_cell_q.bg;
  assign cell_attrs_o     = out_cell_q.attrs;

endmodule

>>> sv/utt_check.sv
// Port-level assertions for the UTF-8 text terminal writer, bound to its top level.
`timescale 1ns / 1ps

module utt_check import utt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  cursor_col_o,
  input logic [5:0]  cursor_row_o,
  input logic [15:0] cell_codepoint_o,
  input logic [7:0]  cell_fg_o,
  input logic [7:0]  cell_bg_o,
  input logic [7:0]  cell_attrs_o
);

  kind_e kind_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_seen_q <= KIND_WRITE;
    end else if (in_valid_i && in_ready_o) begin
      kind_seen_q <= kind_e'(kind_i);
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_col_o) &&
      $stable(cursor_row_o) && $stable(cell_codepoint_o))
    else $error("stalled result changed");

  a_cells_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && (kind_seen_q != KIND_READ) |->
      cell_codepoint_o == 16'd0 && cell_fg_o == 8'd0 && cell_bg_o == 8'd0 &&
      cell_attrs_o == 8'd0)
    else $error("cell fields non-zero for a request other than a read");

  a_clear_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && (kind_seen_q == KIND_CLEAR) |->
      cursor_col_o == 8'd0 && cursor_row_o == 6'd0)
    else $error("cursor not homed after clear screen");

endmodule

bind utf8_text_terminal_writer_top utt_check u_check (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .kind_i           (kind_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .cursor_col_o     (cursor_col_o),
  .cursor_row_o     (cursor_row_o),
  .cell_codepoint_o (cell_codepoint_o),
  .cell_fg_o        (cell_fg_o),
  .cell_bg_o        (cell_bg_o),
  .cell_attrs_o     (cell_attrs_o)
);
